// File: hw/rtl/map_record_tlv_parser_assert.svh
// ----------------------------------------------------------------------------
// Map record parser assertion macros
// Shared concurrent assertion forms for the parser checks.
// ----------------------------------------------------------------------------
`ifndef MAP_RECORD_TLV_PARSER_ASSERT_SVH
`define MAP_RECORD_TLV_PARSER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define MRTLV_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("map record parser check failed");

// Next-cycle implication, off during reset.
`define MRTLV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("map record parser check failed");

// Next-cycle implication that also holds across reset.
`define MRTLV_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("map record parser check failed");

`endif

// File: hw/rtl/mrtlv_pkg.sv
// ----------------------------------------------------------------------------
// Map record parser package
// Shared types, codes and helper functions for the record parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mrtlv_pkg;

  localparam int DEF_RECORD_OFFSET_BITS = 16;
  localparam int DEF_QUEUE_DEPTH        = 4;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIG_ENDIAN = 2'd2;

  localparam logic [1:0] KIND_POS = 2'd0;
  localparam logic [1:0] KIND_STR = 2'd1;
  localparam logic [1:0] KIND_NUM = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  localparam logic [7:0] TYPE_STR_MAX   = 8'd63;
  localparam logic [7:0] TYPE_NUM4_MIN  = 8'd64;
  localparam logic [7:0] TYPE_NUM4_MAX  = 8'd127;
  localparam logic [7:0] TYPE_NUM2_MIN  = 8'd128;
  localparam logic [7:0] TYPE_NUM2_MAX  = 8'd191;
  localparam logic [7:0] TYPE_NUM1_MIN  = 8'd192;
  localparam logic [7:0] TYPE_NUM1_MAX  = 8'd254;
  localparam logic [7:0] TYPE_END       = 8'hff;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic               big_endian;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] serial;
    logic [7:0]  attr_type;
    logic [31:0] val_a;
    logic [31:0] val_b;
    logic        size_error;
  } entry_t;

  function automatic logic [7:0] numeric_width(input logic [7:0] t);
    logic [7:0] w;
    if (t >= TYPE_NUM4_MIN && t <= TYPE_NUM4_MAX) begin
      w = 8'd4;
    end else if (t >= TYPE_NUM2_MIN && t <= TYPE_NUM2_MAX) begin
      w = 8'd2;
    end else begin
      w = 8'd1;
    end
    return w;
  endfunction

endpackage

// File: hw/rtl/mrtlv_ifs.sv
// ----------------------------------------------------------------------------
// Map record parser channel interfaces
// Valid/ready channels for the byte input, result output and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mrtlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       block_start;

  modport source (output valid, output data_byte, output block_start, input ready);
  modport sink (input valid, input data_byte, input block_start, output ready);
endinterface

interface mrtlv_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [15:0]        serial;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [7:0]         attr_type;
  logic [31:0]        attr_value;
  logic [15:0]        str_offset;
  logic [7:0]         str_length;
  logic               size_error;

  modport source (output valid, output kind, output serial, output pos_x, output pos_y,
                  output attr_type, output attr_value, output str_offset,
                  output str_length, output size_error, input ready);
  modport sink (input valid, input kind, input serial, input pos_x, input pos_y,
                input attr_type, input attr_value, input str_offset,
                input str_length, input size_error, output ready);
endinterface

interface mrtlv_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/map_record_tlv_parser.sv
// ----------------------------------------------------------------------------
// Map record type/length/value parser
// Parses a byte stream of map point records into position, string, numeric
// and record-end results.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                   Beat
//  in_ch     in   data_byte, block_start                    one stream byte
//  out_ch    out  kind, serial, pos_x/y, attr_*, str_*, err one result
//  cfg_ch    in   index, data                               one register write
//
//  One byte is taken per cycle unless the queue is full; the parser phase register
//  is updated every beat. Results reach out_ch via queue and then output register.
//  Synchronous reset clears the parser, the queue, the output valid and config regs.
//  A stalled output fills the queue; in_ch.ready drops only when the queue is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module map_record_tlv_parser import mrtlv_pkg::*; #(
  parameter int RECORD_OFFSET_BITS = DEF_RECORD_OFFSET_BITS,
  parameter int QUEUE_DEPTH        = DEF_QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  mrtlv_in_if.sink     in_ch,
  mrtlv_out_if.source  out_ch,
  mrtlv_cfg_if.sink    cfg_ch
);

  cfg_t   cfg_r;
  logic   q_full;
  logic   q_empty;
  logic   q_push;
  logic   q_pop;
  entry_t q_in;
  entry_t q_out;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_ORIGIN_X:   cfg_r.origin_x   <= $signed(cfg_ch.data);
        REG_ORIGIN_Y:   cfg_r.origin_y   <= $signed(cfg_ch.data);
        REG_BIG_ENDIAN: cfg_r.big_endian <= cfg_ch.data[0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  mrtlv_front #(
    .RECORD_OFFSET_BITS(RECORD_OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  mrtlv_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  mrtlv_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_out),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// File: hw/rtl/mrtlv_front.sv
// ----------------------------------------------------------------------------
// Map record parser front end
// Accepts one stream byte per beat, tracks the record phase and queues
// classified result entries.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrtlv_front import mrtlv_pkg::*; #(
  parameter int RECORD_OFFSET_BITS = DEF_RECORD_OFFSET_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  mrtlv_in_if.sink      in_ch,
  input  cfg_t          cfg,
  input  logic          q_full,
  output logic          push,
  output entry_t        push_entry
);

  localparam int OFF_BYTES = (RECORD_OFFSET_BITS + 7) / 8;
  localparam logic [7:0] OFF_BYTES_B = 8'(OFF_BYTES);

  localparam logic [2:0] PH_X     = 3'd0;
  localparam logic [2:0] PH_Y     = 3'd1;
  localparam logic [2:0] PH_TYPE  = 3'd2;
  localparam logic [2:0] PH_SIZE  = 3'd3;
  localparam logic [2:0] PH_SKIP  = 3'd4;
  localparam logic [2:0] PH_VALUE = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] serial_r, serial_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  size_r, size_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [RECORD_OFFSET_BITS-1:0] xoff_r, xoff_nxt;

  logic        fire;
  logic [2:0]  phase_e;
  logic [15:0] count_e;
  logic [15:0] serial_e;
  logic [31:0] shift_e;
  logic [7:0]  rem_e;
  logic [7:0]  take_total;
  logic [7:0]  take_rem;
  logic [7:0]  take_left;
  logic [1:0]  take_idx;
  logic [31:0] take_shift;
  logic        take_done;
  logic        ended;
  logic [7:0]  num_w;

  assign in_ch.ready = !q_full;
  assign fire = in_ch.valid && in_ch.ready;

  always_comb begin
    if (in_ch.block_start) begin
      phase_e  = PH_X;
      count_e  = '0;
      serial_e = '0;
      shift_e  = '0;
      rem_e    = OFF_BYTES_B;
    end else begin
      phase_e  = phase_r;
      count_e  = count_r;
      serial_e = serial_r;
      shift_e  = shift_r;
      rem_e    = rem_r;
    end
  end

  assign num_w      = numeric_width(type_r);
  assign take_total = (phase_e == PH_VALUE) ? num_w : OFF_BYTES_B;
  assign take_rem   = (rem_e == 8'd0) ? 8'd1 : rem_e;
  assign take_idx   = 2'(take_total - take_rem);
  assign take_left  = take_rem - 8'd1;
  assign take_done  = (take_left == 8'd0);
  assign take_shift = cfg.big_endian ? {shift_e[23:0], in_ch.data_byte}
                    : (shift_e | (32'(in_ch.data_byte) << {take_idx, 3'b000}));

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    serial_nxt = serial_r;
    shift_nxt  = shift_r;
    type_nxt   = type_r;
    size_nxt   = size_r;
    rem_nxt    = rem_r;
    xoff_nxt   = xoff_r;
    push       = 1'b0;
    push_entry = '0;
    ended      = 1'b0;
    if (fire) begin
      phase_nxt  = phase_e;
      serial_nxt = serial_e;
      shift_nxt  = shift_e;
      rem_nxt    = rem_e;
      push_entry.serial = serial_e;
      case (phase_e)
        PH_X: begin
          shift_nxt = take_shift;
          rem_nxt   = take_left;
          if (take_done) begin
            xoff_nxt  = take_shift[RECORD_OFFSET_BITS-1:0];
            shift_nxt = '0;
            rem_nxt   = OFF_BYTES_B;
            phase_nxt = PH_Y;
          end
        end
        PH_Y: begin
          shift_nxt = take_shift;
          rem_nxt   = take_left;
          if (take_done) begin
            push             = 1'b1;
            push_entry.kind  = KIND_POS;
            push_entry.val_a = 32'(xoff_r);
            push_entry.val_b = 32'(take_shift[RECORD_OFFSET_BITS-1:0]);
            shift_nxt        = '0;
            phase_nxt        = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_nxt  = in_ch.data_byte;
          phase_nxt = PH_SIZE;
        end
        PH_SIZE: begin
          size_nxt = in_ch.data_byte;
          if (type_r <= TYPE_STR_MAX) begin
            push                 = 1'b1;
            push_entry.kind      = KIND_STR;
            push_entry.attr_type = type_r;
            push_entry.val_a     = 32'(count_e + 16'd1);
            push_entry.val_b     = 32'(in_ch.data_byte);
            if (in_ch.data_byte == 8'd0) begin
              phase_nxt = PH_TYPE;
            end else begin
              rem_nxt   = in_ch.data_byte;
              phase_nxt = PH_SKIP;
            end
          end else if (type_r == TYPE_END) begin
            push                 = 1'b1;
            push_entry.kind      = KIND_END;
            push_entry.attr_type = TYPE_END;
            serial_nxt           = serial_e + 16'd1;
            ended                = 1'b1;
          end else begin
            rem_nxt   = num_w;
            shift_nxt = '0;
            phase_nxt = PH_VALUE;
          end
        end
        PH_SKIP: begin
          if (rem_e > 8'd1) begin
            rem_nxt = rem_e - 8'd1;
          end else begin
            rem_nxt   = 8'd0;
            phase_nxt = PH_TYPE;
          end
        end
        PH_VALUE: begin
          shift_nxt = take_shift;
          rem_nxt   = take_left;
          if (take_done) begin
            push                  = 1'b1;
            push_entry.kind       = KIND_NUM;
            push_entry.attr_type  = type_r;
            push_entry.val_a      = take_shift;
            push_entry.size_error = (size_r != num_w);
            shift_nxt             = '0;
            phase_nxt             = PH_TYPE;
          end
        end
        default: begin
          phase_nxt = PH_X;
          rem_nxt   = OFF_BYTES_B;
          shift_nxt = '0;
        end
      endcase
      if (ended) begin
        phase_nxt = PH_X;
        rem_nxt   = OFF_BYTES_B;
        shift_nxt = '0;
        count_nxt = '0;
      end else begin
        count_nxt = count_e + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_X;
      count_r  <= '0;
      serial_r <= '0;
      shift_r  <= '0;
      type_r   <= '0;
      size_r   <= '0;
      rem_r    <= OFF_BYTES_B;
      xoff_r   <= '0;
    end else begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      serial_r <= serial_nxt;
      shift_r  <= shift_nxt;
      type_r   <= type_nxt;
      size_r   <= size_nxt;
      rem_r    <= rem_nxt;
      xoff_r   <= xoff_nxt;
    end
  end

endmodule

// File: hw/rtl/mrtlv_fifo.sv
// ----------------------------------------------------------------------------
// Map record parser result queue
// Short first-in first-out queue of classified entries between the parser
// front end and the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrtlv_fifo import mrtlv_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_data,
  output logic   full,
  input  logic   pop,
  output entry_t pop_data,
  output logic   empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  entry_t            mem_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r, wptr_nxt;
  logic [PTR_W-1:0]  rptr_r, rptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + PTR_ONE;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + PTR_ONE;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_ONE;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/mrtlv_back.sv
// ----------------------------------------------------------------------------
// Map record parser output stage
// Takes queued entries, adds the block origin to positions and holds each
// result in the output register until its beat completes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mrtlv_back import mrtlv_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  cfg_t         cfg,
  input  logic         q_empty,
  input  entry_t       q_data,
  output logic         pop,
  mrtlv_out_if.source  out_ch
);

  logic               valid_r, valid_nxt;
  logic [1:0]         kind_r;
  logic [15:0]        serial_r;
  logic signed [31:0] pos_x_r, pos_x_nxt;
  logic signed [31:0] pos_y_r, pos_y_nxt;
  logic [7:0]         attr_type_r;
  logic [31:0]        attr_value_r, attr_value_nxt;
  logic [15:0]        str_offset_r, str_offset_nxt;
  logic [7:0]         str_length_r, str_length_nxt;
  logic               size_error_r;

  assign pop = !q_empty && (!valid_r || out_ch.ready);

  always_comb begin
    pos_x_nxt      = '0;
    pos_y_nxt      = '0;
    attr_value_nxt = '0;
    str_offset_nxt = '0;
    str_length_nxt = '0;
    case (q_data.kind)
      KIND_POS: begin
        pos_x_nxt = $signed($unsigned(cfg.origin_x) + q_data.val_a);
        pos_y_nxt = $signed($unsigned(cfg.origin_y) + q_data.val_b);
      end
      KIND_STR: begin
        str_offset_nxt = q_data.val_a[15:0];
        str_length_nxt = q_data.val_b[7:0];
      end
      KIND_NUM: begin
        attr_value_nxt = q_data.val_a;
      end
      default: begin
        pos_x_nxt = '0;
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (pop) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r       <= q_data.kind;
      serial_r     <= q_data.serial;
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
      attr_type_r  <= q_data.attr_type;
      attr_value_r <= attr_value_nxt;
      str_offset_r <= str_offset_nxt;
      str_length_r <= str_length_nxt;
      size_error_r <= q_data.size_error;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.kind       = kind_r;
  assign out_ch.serial     = serial_r;
  assign out_ch.pos_x      = pos_x_r;
  assign out_ch.pos_y      = pos_y_r;
  assign out_ch.attr_type  = attr_type_r;
  assign out_ch.attr_value = attr_value_r;
  assign out_ch.str_offset = str_offset_r;
  assign out_ch.str_length = str_length_r;
  assign out_ch.size_error = size_error_r;

endmodule

// File: hw/rtl/mrtlv_checker.sv
// ----------------------------------------------------------------------------
// Map record parser checker
// Port-level checks on the result channel, bound to the parser top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "map_record_tlv_parser_assert.svh"

module mrtlv_checker import mrtlv_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [15:0] out_serial,
  input logic [31:0] out_pos_x,
  input logic [31:0] out_pos_y,
  input logic [7:0]  out_attr_type,
  input logic [31:0] out_attr_value,
  input logic [15:0] out_str_offset,
  input logic [7:0]  out_str_length,
  input logic        out_size_error
);

  `MRTLV_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_kind) && $stable(out_serial) && $stable(out_pos_x) &&
    $stable(out_pos_y) && $stable(out_attr_type) && $stable(out_attr_value) &&
    $stable(out_str_offset) && $stable(out_str_length) && $stable(out_size_error))

  `MRTLV_ASSERT_IMPLY(a_pos_only, clk, rst_n, out_valid && out_kind != KIND_POS,
    out_pos_x == 32'd0 && out_pos_y == 32'd0)

  `MRTLV_ASSERT_IMPLY(a_end_type, clk, rst_n, out_valid && out_kind == KIND_END,
    out_attr_type == TYPE_END && out_attr_value == 32'd0 && out_str_length == 8'd0)

  `MRTLV_ASSERT_IMPLY(a_num_only, clk, rst_n, out_valid && out_kind != KIND_NUM,
    out_size_error == 1'b0 && out_attr_value == 32'd0)

  `MRTLV_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, !rst_n, !out_valid)

endmodule

bind map_record_tlv_parser mrtlv_checker u_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_kind       (out_ch.kind),
  .out_serial     (out_ch.serial),
  .out_pos_x      (out_ch.pos_x),
  .out_pos_y      (out_ch.pos_y),
  .out_attr_type  (out_ch.attr_type),
  .out_attr_value (out_ch.attr_value),
  .out_str_offset (out_ch.str_offset),
  .out_str_length (out_ch.str_length),
  .out_size_error (out_ch.size_error)
);

// File: tb/tb_map_record_tlv_parser.sv
// ----------------------------------------------------------------------------
// Map record parser testbench
// Feeds record byte streams into the parser and checks each result beat
// against a predictor of the parser. A short directed walk comes first,
// followed by random records under several origin and byte order settings
// and varied idling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_map_record_tlv_parser;
  import mrtlv_pkg::*;

  localparam int OFS_BYTES = (DEF_RECORD_OFFSET_BITS + 7) / 8;
  localparam logic [31:0] OFS_MASK = 32'((64'd1 << DEF_RECORD_OFFSET_BITS) - 64'd1);
  localparam int STALL_CYCLES = 150;
  localparam int DRAIN_LIMIT = 5000;
  localparam int QUIET_CYCLES = 12;

  typedef enum logic [2:0] {AT_X_OFS, AT_Y_OFS, AT_TYPE, AT_SIZE, AT_SKIP, AT_VALUE} phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] serial;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [7:0]  attr_type;
    logic [31:0] attr_value;
    logic [15:0] str_offset;
    logic [7:0]  str_length;
    logic        size_error;
  } result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       typed;
    result_t    res;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  localparam stim_row_t DIRECTED [29] = '{
    '{8'hff, 1'b1, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b1, '{KIND_POS, 16'd0, 32'h0000ffff, 32'h0000ffff, 8'h00, 32'd0,
                           16'd0, 8'd0, 1'b0}},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{KIND_STR, 16'd0, 32'd0, 32'd0, 8'h00, 32'd0, 16'd6, 8'd0, 1'b0}},
    '{8'h3f, 1'b0, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b1, '{KIND_STR, 16'd0, 32'd0, 32'd0, 8'h3f, 32'd0, 16'd8, 8'd1, 1'b0}},
    '{8'haa, 1'b0, 1'b0, NO_RES},
    '{8'h40, 1'b0, 1'b0, NO_RES},
    '{8'h04, 1'b0, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b0, NO_RES},
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'h03, 1'b0, 1'b0, NO_RES},
    '{8'h04, 1'b0, 1'b1, '{KIND_NUM, 16'd0, 32'd0, 32'd0, 8'h40, 32'h04030201, 16'd0,
                           8'd0, 1'b0}},
    '{8'hbf, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h80, 1'b0, 1'b1, '{KIND_NUM, 16'd0, 32'd0, 32'd0, 8'hbf, 32'h00008000, 16'd0,
                           8'd0, 1'b1}},
    '{8'hfe, 1'b0, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b0, NO_RES},
    '{8'hff, 1'b0, 1'b1, '{KIND_NUM, 16'd0, 32'd0, 32'd0, 8'hfe, 32'h000000ff, 16'd0,
                           8'd0, 1'b1}},
    '{8'hff, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{KIND_END, 16'd0, 32'd0, 32'd0, 8'hff, 32'd0, 16'd0, 8'd0, 1'b0}},
    '{8'h12, 1'b0, 1'b0, NO_RES},
    '{8'h05, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h06, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b1, '{KIND_POS, 16'd0, 32'd5, 32'd6, 8'h00, 32'd0, 16'd0, 8'd0, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst_n;

  mrtlv_in_if  in_ch ();
  mrtlv_out_if out_ch ();
  mrtlv_cfg_if cfg_ch ();

  map_record_tlv_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  logic [31:0] org_x;
  logic [31:0] org_y;
  logic        be;

  phase_t      ph;
  logic [15:0] rec_bytes;
  logic [15:0] serial_ctr;
  logic [31:0] acc;
  logic [7:0]  cur_type;
  logic [7:0]  cur_size;
  logic [7:0]  left;
  logic [31:0] x_hold;

  result_t awaited [$];
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      stall_req = 1'b0;
  int      stall_left = 0;

  always #5 clk = ~clk;

  function automatic logic [7:0] value_width(input logic [7:0] t);
    case (t[7:6])
      2'b01:   return 8'd4;
      2'b10:   return 8'd2;
      default: return 8'd1;
    endcase
  endfunction

  function automatic void open_record();
    ph = AT_X_OFS;
    left = 8'(OFS_BYTES);
    acc = '0;
    rec_bytes = '0;
  endfunction

  function automatic void reset_model();
    org_x = '0;
    org_y = '0;
    be = 1'b0;
    serial_ctr = '0;
    cur_type = '0;
    cur_size = '0;
    x_hold = '0;
    open_record();
  endfunction

  function automatic bit fold_in(input logic [7:0] b, input logic [7:0] total);
    logic [1:0] idx;
    if (left == 8'd0) left = 8'd1;
    idx = 2'(total - left);
    if (be) acc = {acc[23:0], b};
    else acc = acc | (32'(b) << (8 * idx));
    left = left - 8'd1;
    return left == 8'd0;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic restart, output result_t r);
    bit hit;
    bit ended;
    r = '0;
    hit = 1'b0;
    ended = 1'b0;
    if (restart) begin
      open_record();
      serial_ctr = '0;
    end
    case (ph)
      AT_X_OFS: begin
        if (fold_in(b, 8'(OFS_BYTES))) begin
          x_hold = acc & OFS_MASK;
          acc = '0;
          left = 8'(OFS_BYTES);
          ph = AT_Y_OFS;
        end
      end
      AT_Y_OFS: begin
        if (fold_in(b, 8'(OFS_BYTES))) begin
          r.kind = KIND_POS;
          r.serial = serial_ctr;
          r.pos_x = org_x + x_hold;
          r.pos_y = org_y + (acc & OFS_MASK);
          hit = 1'b1;
          acc = '0;
          ph = AT_TYPE;
        end
      end
      AT_TYPE: begin
        cur_type = b;
        ph = AT_SIZE;
      end
      AT_SIZE: begin
        cur_size = b;
        if (cur_type <= TYPE_STR_MAX) begin
          r.kind = KIND_STR;
          r.serial = serial_ctr;
          r.attr_type = cur_type;
          r.str_offset = rec_bytes + 16'd1;
          r.str_length = b;
          hit = 1'b1;
          if (b == 8'd0) begin
            ph = AT_TYPE;
          end else begin
            left = b;
            ph = AT_SKIP;
          end
        end else if (cur_type == TYPE_END) begin
          r.kind = KIND_END;
          r.serial = serial_ctr;
          r.attr_type = TYPE_END;
          hit = 1'b1;
          serial_ctr = serial_ctr + 16'd1;
          ended = 1'b1;
        end else begin
          left = value_width(cur_type);
          acc = '0;
          ph = AT_VALUE;
        end
      end
      AT_SKIP: begin
        if (left > 8'd0) left = left - 8'd1;
        if (left == 8'd0) ph = AT_TYPE;
      end
      default: begin
        if (fold_in(b, value_width(cur_type))) begin
          r.kind = KIND_NUM;
          r.serial = serial_ctr;
          r.attr_type = cur_type;
          r.attr_value = acc;
          r.size_error = (cur_size != value_width(cur_type));
          hit = 1'b1;
          acc = '0;
          ph = AT_TYPE;
        end
      end
    endcase
    if (ended) open_record();
    else rec_bytes = rec_bytes + 16'd1;
    return hit;
  endfunction

  task automatic log_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    if (mismatches < 50) begin
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
    end
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
    if (got !== want) log_mismatch(what, got, want);
  endtask

  task automatic send_byte(input logic [7:0] b, input logic restart,
                           input bit has_typed = 1'b0, input result_t typed = '0);
    bit      hit;
    result_t r;
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.block_start <= restart;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    bytes_sent++;
    hit = parse_byte(b, restart, r);
    if (has_typed) awaited.push_back(typed);
    else if (hit) awaited.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= d;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    case (idx)
      REG_ORIGIN_X: org_x = d;
      REG_ORIGIN_Y: org_y = d;
      REG_BIG_ENDIAN: be = d[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (awaited.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (awaited.size() != 0) begin
      log_mismatch("results never delivered", awaited.size(), 0);
      awaited.delete();
    end
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic random_record(input bit fresh);
    int          cls;
    logic [7:0]  t;
    logic [7:0]  sz;
    logic [7:0]  w;
    send_byte(8'($urandom), fresh);
    repeat (2 * OFS_BYTES - 1) send_byte(8'($urandom), 1'b0);
    repeat ($urandom_range(5)) begin
      cls = $urandom_range(9);
      if (cls < 3) begin
        t = 8'($urandom_range(63));
        sz = ($urandom_range(15) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6));
        send_byte(t, 1'b0);
        send_byte(sz, 1'b0);
        repeat (sz) send_byte(8'($urandom), 1'b0);
      end else begin
        if (cls < 5) t = 8'($urandom_range(127, 64));
        else if (cls < 7) t = 8'($urandom_range(191, 128));
        else t = 8'($urandom_range(254, 192));
        w = value_width(t);
        sz = ($urandom_range(4) == 0) ? 8'($urandom) : w;
        send_byte(t, 1'b0);
        send_byte(sz, 1'b0);
        repeat (w) send_byte(8'($urandom), 1'b0);
      end
    end
    send_byte(TYPE_END, 1'b0);
    send_byte(8'($urandom), 1'b0);
  endtask

  task automatic dense_record();
    send_byte(8'($urandom), 1'b1);
    repeat (2 * OFS_BYTES - 1) send_byte(8'($urandom), 1'b0);
    repeat (40) begin
      send_byte(8'($urandom_range(254, 192)), 1'b0);
      send_byte(8'd1, 1'b0);
      send_byte(8'($urandom), 1'b0);
    end
    send_byte(TYPE_END, 1'b0);
    send_byte(8'd0, 1'b0);
  endtask

  always @(negedge clk) begin
    if (stall_req) begin
      stall_left = STALL_CYCLES;
      stall_req = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited.size() == 0) begin
        log_mismatch("result beat with nothing expected", 32'(out_ch.kind), 0);
      end else begin
        want = awaited.pop_front();
        check_field("kind", 32'(out_ch.kind), 32'(want.kind));
        check_field("serial", 32'(out_ch.serial), 32'(want.serial));
        check_field("pos_x", out_ch.pos_x, want.pos_x);
        check_field("pos_y", out_ch.pos_y, want.pos_y);
        check_field("attr_type", 32'(out_ch.attr_type), 32'(want.attr_type));
        check_field("attr_value", out_ch.attr_value, want.attr_value);
        check_field("str_offset", 32'(out_ch.str_offset), 32'(want.str_offset));
        check_field("str_length", 32'(out_ch.str_length), 32'(want.str_length));
        check_field("size_error", 32'(out_ch.size_error), 32'(want.size_error));
      end
    end
  end

  initial begin
    #30_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [31:0] ox [6];
    logic [31:0] oy [6];
    logic        eo [6];
    int          mark;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.block_start = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ORIGIN_X;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    send_idle_pct = 7;
    recv_idle_pct = 65;
    reset_model();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) begin
      send_byte(DIRECTED[i].data, DIRECTED[i].restart, DIRECTED[i].typed, DIRECTED[i].res);
    end

    ox[0] = 32'h7fffffff; oy[0] = 32'h80000000; eo[0] = 1'b1;
    ox[1] = 32'h80000000; oy[1] = 32'hffffffff; eo[1] = 1'b0;
    for (int k = 2; k < 6; k++) begin
      ox[k] = $urandom;
      oy[k] = $urandom;
      eo[k] = 1'($urandom);
    end
    eo[2] = 1'b1;
    eo[3] = 1'b0;

    for (int k = 0; k < 6; k++) begin
      if (k == 2) begin
        send_idle_pct = 65;
        recv_idle_pct = 7;
      end
      if (k == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      write_reg(REG_ORIGIN_X, ox[k]);
      write_reg(REG_ORIGIN_Y, oy[k]);
      write_reg(REG_BIG_ENDIAN, {31'd0, eo[k]});
      if (k == 4) begin
        // The receiver holds off while a record dense with results goes in.
        stall_req = 1'b1;
        dense_record();
      end
      mark = bytes_sent;
      random_record(1'b1);
      while (bytes_sent - mark < 120) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(8, 1)) send_byte(8'($urandom), $urandom_range(7) == 0);
          random_record(1'b1);
        end else begin
          random_record($urandom_range(3) == 0);
        end
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
